// ===== rtl/wsts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsts_pkg
// shared types and codes of the work stealing task scheduler
// ----------------------------------------------------------------------------
package wsts_pkg;

  localparam int KIND_W   = 1;
  localparam int WORKER_W = 3;
  localparam int ID_W     = 16;
  localparam int SRC_W    = 2;

  // number of workers, tied to the width of the worker field
  localparam int WORKERS  = 8;

  localparam logic [SRC_W-1:0] SRC_OWN    = 2'd0;
  localparam logic [SRC_W-1:0] SRC_SHARED = 2'd1;
  localparam logic [SRC_W-1:0] SRC_STOLEN = 2'd2;
  localparam logic [SRC_W-1:0] SRC_NONE   = 2'd3;

  localparam logic KIND_SUBMIT  = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // one classified word from the front part to the back part
  typedef struct packed {
    logic                kind;
    logic [WORKER_W-1:0] worker;
    logic                from_pool;
    logic [ID_W-1:0]     task_id;
  } cmd_t;

  typedef struct packed {
    logic                granted;
    logic [ID_W-1:0]     task_out;
    logic [SRC_W-1:0]    source;
    logic [WORKER_W-1:0] victim;
    logic                full_res;
  } res_t;

endpackage

// ===== rtl/wsts_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsts_front
// accepts input words, wraps worker index and task handle, queues them
// ----------------------------------------------------------------------------
module wsts_front import wsts_pkg::*; #(
  parameter int TASK_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic [WORKER_W-1:0] worker,
  input  logic                from_pool,
  input  logic [ID_W-1:0]     task_id,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output cmd_t                cmd
);

  // two-entry queue
  cmd_t       q [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] fill;
  cmd_t       c;
  logic       push, pop;

  always_comb begin
    logic [ID_W-1:0] mask;
    logic [31:0]     wr;
    mask = (TASK_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((32'd1 << TASK_BITS) - 32'd1);
    // wrap the worker index by repeated compare and subtract
    wr = 32'(worker);
    for (int i = 0; i < (1 << WORKER_W); i++) begin
      if (wr >= 32'(WORKERS)) wr = wr - 32'(WORKERS);
    end
    c.kind      = kind;
    c.worker    = WORKER_W'(wr);
    c.from_pool = from_pool;
    c.task_id   = task_id & mask;
  end

  assign in_ready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= c;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/wsts_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsts_back
// per-worker deques and shared fifo; runs one command at a time
// ----------------------------------------------------------------------------
module wsts_back import wsts_pkg::*; #(
  parameter int DEQUE_DEPTH  = 16,
  parameter int SHARED_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int WB = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int DB = (DEQUE_DEPTH > 1) ? $clog2(DEQUE_DEPTH) : 1;
  localparam int SB = (SHARED_DEPTH > 1) ? $clog2(SHARED_DEPTH) : 1;
  localparam int DC = $clog2(DEQUE_DEPTH + 1);
  localparam int SC = $clog2(SHARED_DEPTH + 1);
  localparam int AB = WB + DB;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_OUT} state_t;

  state_t state;

  logic [ID_W-1:0] dmem [WORKERS*DEQUE_DEPTH];
  logic [ID_W-1:0] smem [SHARED_DEPTH];
  logic [DB-1:0]   dfront [WORKERS];
  logic [DC-1:0]   dcount [WORKERS];
  logic [SB-1:0]   shead, stail;
  logic [SC-1:0]   scount;

  logic [ID_W-1:0] drd, srd;
  logic            rd_shared;

  // steal search: first non-empty deque after the requester
  logic [WB-1:0] vic;
  logic          vic_ok;
  logic [WB-1:0] w;

  assign w = cmd.worker[WB-1:0];

  always_comb begin
    logic [31:0] v;
    vic = '0;
    vic_ok = 1'b0;
    for (int i = WORKERS - 1; i >= 0; i--) begin
      v = 32'(w) + 32'd1 + 32'(i);
      if (v >= 32'(WORKERS)) v = v - 32'(WORKERS);
      if (dcount[v[WB-1:0]] != '0) begin
        vic = v[WB-1:0];
        vic_ok = 1'b1;
      end
    end
  end

  function automatic logic [DB-1:0] dinc(input logic [DB-1:0] p);
    return (32'(p) == DEQUE_DEPTH - 1) ? '0 : p + DB'(1);
  endfunction
  function automatic logic [DB-1:0] ddec(input logic [DB-1:0] p);
    return (p == '0) ? DB'(DEQUE_DEPTH - 1) : p - DB'(1);
  endfunction
  function automatic logic [SB-1:0] sinc(input logic [SB-1:0] p);
    return (32'(p) == SHARED_DEPTH - 1) ? '0 : p + SB'(1);
  endfunction

  function automatic logic [AB-1:0] daddr(input logic [WB-1:0] wi,
                                          input logic [DB-1:0] sl);
    logic [31:0] a;
    a = 32'(wi) * 32'(DEQUE_DEPTH) + 32'(sl);
    return a[AB-1:0];
  endfunction

  assign cmd_ready = (state == S_IDLE) && cmd_valid;
  assign res_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    logic [DB-1:0] nf, bslot;
    logic [31:0]   t;
    res_t          res_next;
    state_t        state_next;
    if (rst) begin
      state  <= S_IDLE;
      shead  <= '0;
      stail  <= '0;
      scount <= '0;
      for (int i = 0; i < WORKERS; i++) begin
        dfront[i] <= '0;
        dcount[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            res_next = '{granted: 1'b0, task_out: '0, source: SRC_NONE,
                         victim: '0, full_res: 1'b0};
            state_next = S_OUT;
            if (cmd.kind == KIND_SUBMIT) begin
              if (cmd.from_pool) begin
                if (32'(dcount[w]) >= DEQUE_DEPTH) res_next.full_res = 1'b1;
                else begin
                  nf = ddec(dfront[w]);
                  dmem[daddr(w, nf)] <= cmd.task_id;
                  dfront[w] <= nf;
                  dcount[w] <= dcount[w] + DC'(1);
                  res_next.granted = 1'b1;
                end
              end else begin
                if (32'(scount) >= SHARED_DEPTH) res_next.full_res = 1'b1;
                else begin
                  smem[stail] <= cmd.task_id;
                  stail <= sinc(stail);
                  scount <= scount + SC'(1);
                  res_next.granted = 1'b1;
                end
              end
            end else if (dcount[w] != '0) begin
              drd <= dmem[daddr(w, dfront[w])];
              rd_shared <= 1'b0;
              dfront[w] <= dinc(dfront[w]);
              dcount[w] <= dcount[w] - DC'(1);
              res_next.granted = 1'b1;
              res_next.source = SRC_OWN;
              state_next = S_READ;
            end else if (scount != '0) begin
              srd <= smem[shead];
              rd_shared <= 1'b1;
              shead <= sinc(shead);
              scount <= scount - SC'(1);
              res_next.granted = 1'b1;
              res_next.source = SRC_SHARED;
              state_next = S_READ;
            end else if (vic_ok) begin
              // oldest entry sits count-1 slots past the front
              t = 32'(dfront[vic]) + 32'(dcount[vic]) - 32'd1;
              if (t >= 32'(DEQUE_DEPTH)) t = t - 32'(DEQUE_DEPTH);
              bslot = t[DB-1:0];
              drd <= dmem[daddr(vic, bslot)];
              rd_shared <= 1'b0;
              dcount[vic] <= dcount[vic] - DC'(1);
              res_next.granted = 1'b1;
              res_next.source = SRC_STOLEN;
              res_next.victim = WORKER_W'(vic);
              state_next = S_READ;
            end
            res <= res_next;
            state <= state_next;
          end
        end
        S_READ: begin
          res.task_out <= rd_shared ? srd : drd;
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/work_stealing_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_stealing_task_scheduler
// per-worker deques with stealing plus a shared fifo for outside submits
// ----------------------------------------------------------------------------
// channel  direction  handshake          fields
// in       input      in_valid/in_ready  kind worker from_pool task_id
// out      output     out_valid/out_ready granted task_out source victim full_res
//
// a word is registered in the front queue before the back part takes it
// in the back part a submit or an empty request goes from idle to the result
// state, any other request passes the read state first (memory read then result)
// the front holds two words, so it takes up to two more words while a result waits
// reset clears state, pointers and counts only; store contents need no clearing
// stalls on out hold the back part, then the front fills and drops in_ready
// ----------------------------------------------------------------------------
module work_stealing_task_scheduler import wsts_pkg::*; #(
  parameter int DEQUE_DEPTH  = 16,
  parameter int SHARED_DEPTH = 16,
  parameter int TASK_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic [WORKER_W-1:0] worker,
  input  logic                from_pool,
  input  logic [ID_W-1:0]     task_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                granted,
  output logic [ID_W-1:0]     task_out,
  output logic [SRC_W-1:0]    source,
  output logic [WORKER_W-1:0] victim,
  output logic                full_res
);

  cmd_t cmd;
  res_t res;
  logic cmd_valid, cmd_ready;

  wsts_front #(.TASK_BITS(TASK_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .kind, .worker, .from_pool, .task_id,
    .cmd_valid, .cmd_ready, .cmd
  );

  wsts_back #(.DEQUE_DEPTH(DEQUE_DEPTH),
              .SHARED_DEPTH(SHARED_DEPTH)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign granted  = res.granted;
  assign task_out = res.task_out;
  assign source   = res.source;
  assign victim   = res.victim;
  assign full_res = res.full_res;

endmodule
